>>> src/manifest_field_extractor_top_defines.svh
// Assertion macros for the manifest field extractor.
`ifndef MANIFEST_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define MANIFEST_FIELD_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTH
// checked property, disabled while reset is asserted
`define MFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also active during reset
`define MFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFE_ASSERT(lbl, clk, rstn, prop, msg)
`define MFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/mfe_pkg.sv
// Types and constants of the manifest field extractor.
package mfe_pkg;

    // capture phase of the quoted fields (version, sha256)
    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_OPENQ  = 5'b00010,
        PH_CAPT   = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAIL   = 5'b10000
    } phase_t;

    // parse phase of the size field
    typedef enum logic [4:0] {
        SZ_SEARCH = 5'b00001,
        SZ_WS     = 5'b00010,
        SZ_SIGN   = 5'b00100,
        SZ_DIGITS = 5'b01000,
        SZ_DONE   = 5'b10000
    } size_phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // keys without their colon; first character in the high byte
    localparam logic [71:0] KEY_VERSION = "\"version\"";
    localparam logic [47:0] KEY_SIZE    = "\"size\"";
    localparam logic [63:0] KEY_SHA     = "\"sha256\"";

    localparam int HASH_DIGITS = 64;
    localparam int VER_WORD_BYTES = 16;

    // word_index codes
    localparam logic [2:0] WORD_STATUS = 3'd0;
    localparam logic [2:0] WORD_VER_LO = 3'd1;
    localparam logic [2:0] WORD_VER_HI = 3'd2;
    localparam logic [2:0] WORD_HASH_0 = 3'd3;
    localparam logic [2:0] WORD_HASH_1 = 3'd4;
    localparam logic [2:0] WORD_HASH_2 = 3'd5;
    localparam logic [2:0] WORD_HASH_3 = 3'd6;

endpackage

>>> src/manifest_field_extractor_top.sv
// Manifest field extractor: version, size and sha256 parse over a byte stream.
`include "manifest_field_extractor_top_defines.svh"

// One manifest byte is taken per cycle while s_axis_tready is high. Three
// matchers watch a nine-byte window for "version":, "size": and "sha256": and
// capture the values as the bytes go by. On the byte marked tlast the parsed
// fields are latched into a result bank and the parser returns to its reset
// state, so the next buffer may start on the following cycle. The bank drains
// one result per cycle while m_axis_tready is high: seven results (tuser 0
// status, 1-2 version, 3-6 hash) for a good manifest, a single zero status
// result otherwise. Bytes that are not a buffer's last keep flowing while the
// bank drains; a last byte is held off until the final result of the previous
// run is taken, in the same cycle at the earliest.
module manifest_field_extractor_top
    import mfe_pkg::*;
#(
    parameter int VERSION_BYTES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
    input  logic         s_axis_tlast,   // end_of_buffer
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] word_data, [64] manifest_ok, [96:65] image_size,
    // [100:97] version_length, [103:101] zero
    output logic [103:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] word_index
    output logic         m_axis_tlast    // last_result
);

    localparam int VCOUNT_W = $clog2(VERSION_BYTES);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX = VCOUNT_W'(VERSION_BYTES - 1);

    // parser state
    logic [71:0]         win_reg, win_next;
    phase_t              ver_ph_reg, ver_ph_next;
    phase_t              hash_ph_reg, hash_ph_next;
    size_phase_t         size_ph_reg, size_ph_next;
    logic [7:0]          vstore_reg [VER_WORD_BYTES];
    logic [7:0]          vstore_next [VER_WORD_BYTES];
    logic [VCOUNT_W-1:0] vcnt_reg, vcnt_next;
    logic [31:0]         acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                sat_reg, sat_next;
    logic [3:0]          hstore_reg [HASH_DIGITS];
    logic [3:0]          hstore_next [HASH_DIGITS];
    logic [6:0]          hcnt_reg, hcnt_next;

    // result bank and drain control
    logic                active_reg;
    logic [2:0]          pos_reg;
    logic                snap_ok_reg;
    logic [31:0]         snap_size_reg;
    logic [3:0]          snap_vlen_reg;
    logic [127:0]        snap_ver_reg;
    logic [255:0]        snap_hash_reg;

    logic                fin_ok;
    logic [31:0]         fin_size;
    logic [3:0]          fin_vlen;
    logic [127:0]        fin_ver;
    logic [255:0]        fin_hash;

    logic                s_hs, m_hs, load, drain_free, m_tlast_o;
    logic [63:0]         word_data;

    assign m_tlast_o     = !snap_ok_reg || (pos_reg == WORD_HASH_3);
    assign drain_free    = !active_reg || (m_axis_tready && m_tlast_o);
    assign s_axis_tready = !s_axis_tlast || drain_free;
    assign s_hs          = s_axis_tvalid && s_axis_tready;
    assign load          = s_hs && s_axis_tlast;
    assign m_hs          = active_reg && m_axis_tready;

    always_comb begin
        logic [7:0]  c;
        logic        last;
        logic        is_digit;
        logic        is_space;
        logic        is_hex;
        logic [3:0]  hex_val;
        logic [35:0] prod;
        logic        vok;

        c        = s_axis_tdata;
        last     = s_axis_tlast;
        is_digit = (c >= "0") && (c <= "9");
        is_space = (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
        is_hex   = is_digit || (c inside {["a":"f"]}) || (c inside {["A":"F"]});
        hex_val  = is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);
        prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, c[3:0]};

        win_next     = {win_reg[63:0], c};
        ver_ph_next  = ver_ph_reg;
        hash_ph_next = hash_ph_reg;
        size_ph_next = size_ph_reg;
        vstore_next  = vstore_reg;
        vcnt_next    = vcnt_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        hstore_next  = hstore_reg;
        hcnt_next    = hcnt_reg;

        case (ver_ph_reg)
            PH_SEARCH: begin
                if (!last && win_reg == KEY_VERSION && c == CH_COLON) begin
                    ver_ph_next = PH_OPENQ;
                end
            end
            PH_OPENQ: begin
                ver_ph_next = (c == CH_QUOTE && !last) ? PH_CAPT : PH_FAIL;
            end
            PH_CAPT: begin
                if (c == CH_QUOTE) begin
                    ver_ph_next = (vcnt_reg != '0) ? PH_DONE : PH_FAIL;
                end else if (vcnt_reg < VCOUNT_MAX) begin
                    // only the first fifteen characters are kept; a longer value fails the version
                    for (int i = 0; i < VER_WORD_BYTES; i++) begin
                        if (int'(vcnt_reg) == i) begin
                            vstore_next[i] = c;
                        end
                    end
                    vcnt_next = vcnt_reg + 1'b1;
                end else begin
                    ver_ph_next = PH_FAIL;
                end
            end
            default: ;
        endcase

        case (size_ph_reg)
            SZ_SEARCH: begin
                if (!last && win_reg[47:0] == KEY_SIZE && c == CH_COLON) begin
                    size_ph_next = SZ_WS;
                end
            end
            SZ_WS: begin
                if (is_space) begin
                    size_ph_next = SZ_WS;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_next     = (c == CH_MINUS);
                    size_ph_next = SZ_SIGN;
                end else if (is_digit) begin
                    acc_next     = {28'd0, c[3:0]};
                    size_ph_next = SZ_DIGITS;
                end else begin
                    size_ph_next = SZ_DONE;
                end
            end
            SZ_SIGN: begin
                if (is_digit) begin
                    acc_next     = {28'd0, c[3:0]};
                    size_ph_next = SZ_DIGITS;
                end else begin
                    size_ph_next = SZ_DONE;
                end
            end
            SZ_DIGITS: begin
                if (is_digit) begin
                    if (!sat_reg) begin
                        if (prod[35:32] != 4'd0) begin
                            sat_next = 1'b1;
                        end else begin
                            acc_next = prod[31:0];
                        end
                    end
                end else begin
                    size_ph_next = SZ_DONE;
                end
            end
            default: ;
        endcase

        case (hash_ph_reg)
            PH_SEARCH: begin
                if (!last && win_reg[63:0] == KEY_SHA && c == CH_COLON) begin
                    hash_ph_next = PH_OPENQ;
                end
            end
            PH_OPENQ: begin
                hash_ph_next = (c == CH_QUOTE && !last) ? PH_CAPT : PH_FAIL;
            end
            PH_CAPT: begin
                if (c == CH_QUOTE) begin
                    hash_ph_next = (int'(hcnt_reg) == HASH_DIGITS) ? PH_DONE : PH_FAIL;
                end else if (int'(hcnt_reg) < HASH_DIGITS && is_hex) begin
                    hstore_next[hcnt_reg[5:0]] = hex_val;
                    hcnt_next = hcnt_reg + 7'd1;
                end else begin
                    hash_ph_next = PH_FAIL;
                end
            end
            default: ;
        endcase

        // run summary from the state after this byte
        vok = (ver_ph_next == PH_DONE) || (ver_ph_next == PH_CAPT && vcnt_next != '0);
        if (size_ph_next == SZ_SEARCH) begin
            fin_size = 32'd0;
        end else if (sat_next) begin
            fin_size = 32'hFFFF_FFFF;
        end else begin
            fin_size = neg_next ? (32'd0 - acc_next) : acc_next;
        end
        fin_ok   = vok && (fin_size != 32'd0) && (hash_ph_next == PH_DONE);
        fin_vlen = (int'(vcnt_next) > 15) ? 4'd15 : 4'(vcnt_next);
        for (int b = 0; b < VER_WORD_BYTES; b++) begin
            fin_ver[8*b +: 8] = (int'(vcnt_next) > b) ? vstore_next[b] : 8'd0;
        end
        // first digit of each group of sixteen lands in the high nibble
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 16; k++) begin
                fin_hash[64*j + 4*(15-k) +: 4] = hstore_next[16*j + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            ver_ph_reg  <= PH_SEARCH;
            hash_ph_reg <= PH_SEARCH;
            size_ph_reg <= SZ_SEARCH;
            vcnt_reg    <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
            hcnt_reg    <= '0;
        end else if (load) begin
            win_reg     <= '0;
            ver_ph_reg  <= PH_SEARCH;
            hash_ph_reg <= PH_SEARCH;
            size_ph_reg <= SZ_SEARCH;
            vcnt_reg    <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
            hcnt_reg    <= '0;
        end else if (s_hs) begin
            win_reg     <= win_next;
            ver_ph_reg  <= ver_ph_next;
            hash_ph_reg <= hash_ph_next;
            size_ph_reg <= size_ph_next;
            vcnt_reg    <= vcnt_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            sat_reg     <= sat_next;
            hcnt_reg    <= hcnt_next;
        end
    end

    // capture stores hold no reset; unwritten entries are masked by the counts
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            vstore_reg <= vstore_next;
            hstore_reg <= hstore_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            snap_ok_reg   <= fin_ok;
            snap_size_reg <= fin_size;
            snap_vlen_reg <= fin_vlen;
            snap_ver_reg  <= fin_ver;
            snap_hash_reg <= fin_hash;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pos_reg    <= WORD_STATUS;
        end else if (load) begin
            active_reg <= 1'b1;
            pos_reg    <= WORD_STATUS;
        end else if (m_hs) begin
            if (m_tlast_o) begin
                active_reg <= 1'b0;
                pos_reg    <= WORD_STATUS;
            end else begin
                pos_reg    <= pos_reg + 3'd1;
            end
        end
    end

    always_comb begin
        case (pos_reg)
            WORD_STATUS: word_data = 64'd0;
            WORD_VER_LO: word_data = snap_ver_reg[63:0];
            WORD_VER_HI: word_data = snap_ver_reg[127:64];
            WORD_HASH_0: word_data = snap_hash_reg[63:0];
            WORD_HASH_1: word_data = snap_hash_reg[127:64];
            WORD_HASH_2: word_data = snap_hash_reg[191:128];
            WORD_HASH_3: word_data = snap_hash_reg[255:192];
            default:     word_data = 64'd0;
        endcase
    end

    assign m_axis_tvalid = active_reg;
    assign m_axis_tlast  = m_tlast_o;
    // a failed run stays at the status item
    assign m_axis_tuser  = pos_reg;
    // a failed run reports all zeros
    assign m_axis_tdata  = snap_ok_reg ?
                           {3'b000, snap_vlen_reg, snap_size_reg, 1'b1, word_data} : '0;

    `MFE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "output valid after reset")
    `MFE_ASSERT(a_pos_step, aclk, aresetn, (m_hs && !m_tlast_o) |=> (active_reg && pos_reg == $past(pos_reg) + 3'd1), "drain position did not advance")
    `MFE_ASSERT(a_fail_single, aclk, aresetn, (active_reg && !snap_ok_reg) |-> (pos_reg == WORD_STATUS), "failed run past status item")
    `MFE_ASSERT(a_ok_size, aclk, aresetn, (active_reg && snap_ok_reg) |-> (snap_size_reg != 32'd0), "good run with zero size")
    `MFE_ASSERT(a_run_reset, aclk, aresetn, load |=> (ver_ph_reg == PH_SEARCH && hash_ph_reg == PH_SEARCH && size_ph_reg == SZ_SEARCH && win_reg == 72'd0), "parser not cleared after last item")

endmodule
